// File: hdl/tccs_pkg.sv
// Shared types and constants for the text console engine.
`timescale 1ns / 1ps
package tccs_pkg;

	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int CELL_W    = 16;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;
	localparam int COLOR_W   = 8;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
	localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;
	localparam logic [CELL_W-1:0]  BLANK_CELL   = {COLOR_RESET, SPACE_CODE};

	typedef enum logic [2:0] {
		K_PUT,
		K_NEWLINE,
		K_CLEAR,
		K_READ,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
		logic              index_ok;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_RESP
	} back_state_t;

endpackage

// File: hdl/tccs_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface tccs_req_if;
	import tccs_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, operation, char_code, cell_index, input ready);
	modport sink (input valid, operation, char_code, cell_index, output ready);
endinterface

interface tccs_rsp_if;
	import tccs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CELL_W-1:0]    cell_data;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [COL_OUT_W-1:0] cursor_column;
	logic                 scrolled;

	modport source (output valid, cell_data, cursor_row, cursor_column, scrolled, input ready);
	modport sink (input valid, cell_data, cursor_row, cursor_column, scrolled, output ready);
endinterface

// File: hdl/text_console_cursor_scroll.sv
// Top level of the text console engine.
//
//   channel  | dir | handshake         | payload
//   req      | in  | req.valid/ready   | operation, char_code, cell_index
//   rsp      | out | rsp.valid/ready   | cell_data, cursor_row, cursor_column, scrolled
//   cfg      | in  | cfg_we            | cfg_wdata (text color)
//
// Put, read, unused codes and a newline that does not scroll go from the queue through idle to the result state.
// A scrolling newline copies all rows below the top up by one row through the screen memory,
// then writes a row of blanks; clear blanks every cell of the screen.
// After reset the screen memory is blanked with req.ready low.
// A two-item queue and the result register buffer the sides; a stall on rsp fills the queue, then drops req.ready.
`timescale 1ns / 1ps
module text_console_cursor_scroll #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tccs_req_if.sink                     req,
	tccs_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [tccs_pkg::COLOR_W-1:0] cfg_wdata
);
	import tccs_pkg::*;

	logic busy;
	logic q_full, q_push, q_valid, q_pop;
	cmd_t q_cmd, q_head;

	tccs_front #(
		.CELLS (ROWS * COLUMNS)
	) u_front (
		.busy   (busy),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	tccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (q_pop),
		.head      (q_head)
	);

	tccs_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.busy      (busy),
		.rsp       (rsp)
	);

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.scrolled |->
			rsp.cursor_row == ROW_OUT_W'(ROWS - 1) && rsp.cursor_column == '0)
		else $error("scroll result with cursor off the last row start");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.cursor_column) < COLUMNS)
		else $error("cursor column beyond screen width");

	a_init_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready)
		else $error("item accepted during screen init");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full command queue");

endmodule

// File: hdl/tccs_front.sv
// Front end: accepts request items and classifies them into commands.
`timescale 1ns / 1ps
module tccs_front #(
	parameter int unsigned CELLS = 2000
) (
	input  logic          busy,
	tccs_req_if.sink      req,
	input  logic          q_full,
	output logic          q_push,
	output tccs_pkg::cmd_t q_cmd
);
	import tccs_pkg::*;

	always_comb begin
		q_cmd.char_code  = req.char_code;
		q_cmd.cell_index = req.cell_index;
		q_cmd.index_ok   = (32'(req.cell_index) < CELLS);
		unique case (req.operation)
			OP_PUT:   q_cmd.kind = (req.char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT;
			OP_CLEAR: q_cmd.kind = K_CLEAR;
			OP_READ:  q_cmd.kind = K_READ;
			default:  q_cmd.kind = K_NOP;
		endcase
	end

	assign req.ready = !q_full && !busy;
	assign q_push    = req.valid && req.ready;

endmodule

// File: hdl/tccs_queue.sv
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module tccs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tccs_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output tccs_pkg::cmd_t head
);
	import tccs_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PW    = $clog2(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/tccs_back.sv
// Back end: screen memory, cursor, scroll/clear sequencer and result register.
`timescale 1ns / 1ps
module tccs_back #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tccs_pkg::COLOR_W-1:0]  cfg_wdata,
	input  logic                          q_valid,
	input  tccs_pkg::cmd_t                q_head,
	output logic                          q_pop,
	output logic                          busy,
	tccs_rsp_if.source                    rsp
);
	import tccs_pkg::*;

	localparam int unsigned CELLS = ROWS * COLUMNS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned RW    = $clog2(ROWS);
	localparam int unsigned CW    = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] ROW_STEP      = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
	localparam logic [AW:0]   COPY_START    = (AW+1)'(COLUMNS);
	localparam logic [AW:0]   COPY_END      = (AW+1)'(CELLS);

	back_state_t state_q, state_d;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [CELL_W-1:0] mem_wd;

	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [AW-1:0]      base_q;
	logic [COLOR_W-1:0] color_q;

	cmd_t              cur_q;
	logic              scrolled_q;
	logic [AW:0]       cp_q;
	logic              pend_q;
	logic [AW-1:0]     pend_addr_q;
	logic [AW-1:0]     fp_q;
	logic [CELL_W-1:0] fill_val_q;

	logic                 rsp_valid_q;
	logic [CELL_W-1:0]    rsp_data_q;
	logic [ROW_OUT_W-1:0] rsp_row_q;
	logic [COL_OUT_W-1:0] rsp_col_q;
	logic                 rsp_scrolled_q;

	logic row_last, col_last, copy_done, fill_done, rsp_free, rsp_load, scroll_now;

	assign row_last   = (row_q == RW'(ROWS - 1));
	assign col_last   = (col_q == CW'(COLUMNS - 1));
	assign copy_done  = (cp_q == COPY_END);
	assign fill_done  = (fp_q == LAST_CELL);
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign rsp_load   = (state_q == ST_RESP) && rsp_free;
	assign scroll_now = q_pop && (q_head.kind == K_NEWLINE) && row_last;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.cell_data     = rsp_data_q;
	assign rsp.cursor_row    = rsp_row_q;
	assign rsp.cursor_column = rsp_col_q;
	assign rsp.scrolled      = rsp_scrolled_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (fill_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_head.kind)
						K_NEWLINE: state_d = row_last ? ST_COPY : ST_RESP;
						K_CLEAR:   state_d = ST_FILL;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_COPY: begin
				if (copy_done) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (fill_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control and handshake outputs
	always_comb begin
		q_pop  = (state_q == ST_IDLE) && q_valid;
		busy   = (state_q == ST_INIT);
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = fp_q;
		mem_ra = cp_q[AW-1:0];
		mem_wd = fill_val_q;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wd = BLANK_CELL;
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (q_valid && q_head.kind == K_PUT) begin
					mem_we = 1'b1;
					mem_wa = base_q + AW'(col_q);
					mem_wd = {color_q, q_head.char_code};
				end
				if (q_valid && q_head.kind == K_READ && q_head.index_ok) begin
					mem_re = 1'b1;
					mem_ra = AW'(q_head.cell_index);
				end
			end
			ST_COPY: begin
				mem_re = !copy_done;
			end
			default: begin
			end
		endcase
		// copy write-back happens in the cycle after the read
		if (pend_q) begin
			mem_we = 1'b1;
			mem_wa = pend_addr_q;
			mem_wd = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			color_q     <= COLOR_RESET;
			cp_q        <= '0;
			pend_q      <= 1'b0;
			fp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= mem_re && (state_q == ST_COPY);
			if (state_q == ST_COPY && !copy_done) begin
				cp_q <= cp_q + 1'b1;
			end
			if (state_q == ST_INIT || state_q == ST_FILL) begin
				fp_q <= fill_done ? '0 : fp_q + 1'b1;
			end
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (q_pop) begin
				unique case (q_head.kind)
					K_PUT: begin
						if (col_last) begin
							col_q <= '0;
							if (row_last) begin
								row_q  <= '0;
								base_q <= '0;
							end else begin
								row_q  <= row_q + 1'b1;
								base_q <= base_q + ROW_STEP;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
					K_NEWLINE: begin
						col_q <= '0;
						if (row_last) begin
							cp_q <= COPY_START;
							fp_q <= LAST_ROW_BASE;
						end else begin
							row_q  <= row_q + 1'b1;
							base_q <= base_q + ROW_STEP;
						end
					end
					K_CLEAR: begin
						row_q   <= '0;
						col_q   <= '0;
						base_q  <= '0;
						fp_q    <= '0;
						color_q <= COLOR_RESET;
					end
					default: begin
					end
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_q <= cp_q[AW-1:0] - ROW_STEP;
		if (q_pop) begin
			cur_q      <= q_head;
			scrolled_q <= scroll_now;
			fill_val_q <= scroll_now ? {color_q, SPACE_CODE} : BLANK_CELL;
		end
		if (rsp_load) begin
			rsp_data_q     <= (cur_q.kind == K_READ && cur_q.index_ok) ? rdata_q : '0;
			rsp_row_q      <= ROW_OUT_W'(row_q);
			rsp_col_q      <= COL_OUT_W'(col_q);
			rsp_scrolled_q <= scrolled_q;
		end
	end

endmodule
